// ===== hw/rtl/es_pkg.sv =====
package es_pkg;

  // Fixed field widths of one record.
  localparam int KEY_W = 32;
  localparam int TAG_W = 16;

  // Default batch capacity.
  localparam int MAX_RECORDS_DEF = 64;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic mem_we;   // write the record store
    logic wr_cur;   // write data is the held record, not the input word
    logic cur_ld;   // load the held record from the read register
    logic out_ld;   // load the output register from the read register
  } es_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic key_less; // held key is below the key just read (signed)
  } es_sts_t;

endpackage

// ===== hw/rtl/es_if.sv =====
// Input channel: one record per word.
interface es_in_if;
  import es_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key;
  logic [TAG_W-1:0]        tag;
  logic                    last;

  modport source (output valid, key, tag, last, input ready);
  modport sink   (input valid, key, tag, last, output ready);
endinterface

// Result channel: one sorted record per word.
interface es_out_if;
  import es_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key_out;
  logic [TAG_W-1:0]        tag_out;
  logic                    last_out;
  logic                    dropped;

  modport source (output valid, key_out, tag_out, last_out, dropped, input ready);
  modport sink   (input valid, key_out, tag_out, last_out, dropped, output ready);
endinterface

// ===== hw/rtl/exchange_sort_int_keys_core.sv =====
// Batch exchange sorter for records of a signed 32-bit key and a 16-bit tag. Words are
// taken one per cycle into an on-chip store of MAX_RECORDS entries until a word with last
// set arrives; words beyond capacity are dropped and every result of that batch then
// carries dropped. The batch is sorted in ascending signed key order by an exchange sort
// (for each i, for each j below i, swap when key i is below key j), so equal keys end in
// a fixed, repeatable order. The store has one write and one read port, and the sort
// does one compare-and-swap per cycle. Sorted records then leave one at a time: each
// is read into the output register and held until the sink takes it, and only then is
// the next one read; the last one carries last_out. No input is taken from the last
// word of a batch until the last sorted word has been delivered.
module exchange_sort_int_keys_core #(
  parameter int MAX_RECORDS = es_pkg::MAX_RECORDS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  es_in_if.sink    in_ch,
  es_out_if.source out_ch
);
  import es_pkg::*;

  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  es_cmd_t       cmd;
  es_sts_t       sts;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // Sequencer.
  es_ctrl #(.MAX_RECORDS(MAX_RECORDS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_last     (in_ch.last),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_last    (out_ch.last_out),
    .out_dropped (out_ch.dropped),
    .cmd         (cmd),
    .waddr       (waddr),
    .raddr       (raddr),
    .sts         (sts)
  );

  // Record store, held record and output register.
  es_dp #(.MAX_RECORDS(MAX_RECORDS)) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .waddr   (waddr),
    .raddr   (raddr),
    .in_key  (in_ch.key),
    .in_tag  (in_ch.tag),
    .out_key (out_ch.key_out),
    .out_tag (out_ch.tag_out),
    .sts     (sts)
  );

endmodule

// ===== hw/rtl/es_dp.sv =====
module es_dp #(
  parameter int MAX_RECORDS = es_pkg::MAX_RECORDS_DEF,
  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
  input  logic                           clk,
  input  es_pkg::es_cmd_t                cmd,
  input  logic [AW-1:0]                  waddr,
  input  logic [AW-1:0]                  raddr,
  input  logic signed [es_pkg::KEY_W-1:0] in_key,
  input  logic [es_pkg::TAG_W-1:0]       in_tag,
  output logic signed [es_pkg::KEY_W-1:0] out_key,
  output logic [es_pkg::TAG_W-1:0]       out_tag,
  output es_pkg::es_sts_t                sts
);
  import es_pkg::*;

  logic signed [KEY_W-1:0] key_mem [MAX_RECORDS];
  logic [TAG_W-1:0]        tag_mem [MAX_RECORDS];

  logic signed [KEY_W-1:0] rd_key_r;
  logic [TAG_W-1:0]        rd_tag_r;
  logic signed [KEY_W-1:0] cur_key_r;
  logic [TAG_W-1:0]        cur_tag_r;
  logic signed [KEY_W-1:0] out_key_r;
  logic [TAG_W-1:0]        out_tag_r;
  logic signed [KEY_W-1:0] wr_key;
  logic [TAG_W-1:0]        wr_tag;

  // Write data is either the arriving word or the held record.
  assign wr_key = cmd.wr_cur ? cur_key_r : in_key;
  assign wr_tag = cmd.wr_cur ? cur_tag_r : in_tag;

  // Record store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      key_mem[waddr] <= wr_key;
      tag_mem[waddr] <= wr_tag;
    end
    rd_key_r <= key_mem[raddr];
    rd_tag_r <= tag_mem[raddr];
  end

  // Held record i; on a swap it takes the record that was at j.
  always_ff @(posedge clk) begin
    if (cmd.cur_ld) begin
      cur_key_r <= rd_key_r;
      cur_tag_r <= rd_tag_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_key_r <= rd_key_r;
      out_tag_r <= rd_tag_r;
    end
  end

  assign out_key      = out_key_r;
  assign out_tag      = out_tag_r;
  assign sts.key_less = cur_key_r < rd_key_r;

endmodule

// ===== hw/rtl/es_ctrl.sv =====
module es_ctrl #(
  parameter int MAX_RECORDS = es_pkg::MAX_RECORDS_DEF,
  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
  localparam int CW = $clog2(MAX_RECORDS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_last,
  output logic            out_dropped,
  output es_pkg::es_cmd_t cmd,
  output logic [AW-1:0]   waddr,
  output logic [AW-1:0]   raddr,
  input  es_pkg::es_sts_t sts
);
  import es_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RDI  = 3'd1;
  localparam logic [2:0] S_LDI  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_WRI  = 3'd4;
  localparam logic [2:0] S_ERD  = 3'd5;
  localparam logic [2:0] S_ELD  = 3'd6;
  localparam logic [2:0] S_EOUT = 3'd7;

  localparam logic [CW-1:0] CAP = CW'(MAX_RECORDS);
  localparam logic [CW-1:0] ONE = CW'(1);

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic          olast_r, olast_nxt;
  logic          odrop_r, odrop_nxt;

  // Sequencer: load, exchange sort over the store, then drain in order.
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    ovf_nxt    = ovf_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    ovalid_nxt = ovalid_r;
    olast_nxt  = olast_r;
    odrop_nxt  = odrop_r;
    cmd        = '0;
    waddr      = fill_r[AW-1:0];
    raddr      = '0;
    in_ready   = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (fill_r < CAP) begin
            cmd.mem_we = 1'b1;
            fill_nxt   = fill_r + ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt     = ONE;
            state_nxt = S_RDI;
          end
        end
      end
      S_RDI: begin
        if (i_r >= fill_r) begin
          k_nxt     = '0;
          state_nxt = S_ERD;
        end else begin
          raddr     = i_r[AW-1:0];
          state_nxt = S_LDI;
        end
      end
      S_LDI: begin
        cmd.cur_ld = 1'b1;
        raddr      = '0;
        j_nxt      = '0;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        // Swap: store the held record at j and hold the old record j.
        if (sts.key_less) begin
          cmd.mem_we = 1'b1;
          cmd.wr_cur = 1'b1;
          cmd.cur_ld = 1'b1;
          waddr      = j_r;
        end
        if (CW'(j_r) + ONE < i_r) begin
          raddr = j_r + AW'(1);
          j_nxt = j_r + AW'(1);
        end else begin
          state_nxt = S_WRI;
        end
      end
      S_WRI: begin
        cmd.mem_we = 1'b1;
        cmd.wr_cur = 1'b1;
        waddr      = i_r[AW-1:0];
        i_nxt      = i_r + ONE;
        state_nxt  = S_RDI;
      end
      S_ERD: begin
        raddr     = k_r;
        state_nxt = S_ELD;
      end
      S_ELD: begin
        cmd.out_ld = 1'b1;
        ovalid_nxt = 1'b1;
        olast_nxt  = (CW'(k_r) + ONE == fill_r);
        odrop_nxt  = ovf_r;
        state_nxt  = S_EOUT;
      end
      S_EOUT: begin
        if (out_ready) begin
          ovalid_nxt = 1'b0;
          if (olast_r) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      fill_r   <= '0;
      ovf_r    <= 1'b0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      ovalid_r <= 1'b0;
      olast_r  <= 1'b0;
      odrop_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      ovf_r    <= ovf_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      k_r      <= k_nxt;
      ovalid_r <= ovalid_nxt;
      olast_r  <= olast_nxt;
      odrop_r  <= odrop_nxt;
    end
  end

  assign out_valid   = ovalid_r;
  assign out_last    = olast_r;
  assign out_dropped = odrop_r;

  // The fill count never passes the capacity.
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= CAP)
    else $error("fill count above capacity");

  // The inner index stays below the outer index while comparing.
  a_j_below_i: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> CW'(j_r) < i_r)
    else $error("inner index not below outer index");

  // Taking the last word of a batch empties the store and reopens loading.
  a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> fill_r == '0 && !ovf_r && state_r == S_LOAD)
    else $error("batch not cleared after last word");

  // Taking a word that is not last steps to the next stored position.
  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> k_r == $past(k_r) + AW'(1))
    else $error("drain index did not advance");

  // Input is taken only while no result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && ovalid_r))
    else $error("input taken while a result is pending");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import es_pkg::*;

  localparam int CAPACITY = MAX_RECORDS_DEF;
  localparam int TOTAL_WORDS = 420;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam longint LIMIT_NS = 64'd400_000_000;

  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

  // Key patterns used to fill a batch.
  typedef enum int {
    KEYS_FULL,
    KEYS_NARROW,
    KEYS_EDGE
  } key_mix_t;

  // One sorted record as it should leave the block.
  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    logic                    last;
    logic                    dropped;
  } sorted_rec_t;

  logic clk = 1'b0;
  logic rst_n;

  es_in_if  in_ch ();
  es_out_if out_ch ();

  exchange_sort_int_keys_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the batch store and the expected sorted words.
  logic signed [KEY_W-1:0] batch_keys [CAPACITY];
  logic [TAG_W-1:0]        batch_tags [CAPACITY];
  int unsigned             batch_fill = 0;
  bit                      batch_overflow = 1'b0;
  sorted_rec_t             expected_recs [$];

  int  mismatches = 0;
  int  words_sent = 0;
  bit  quiet_gaps = 1'b0;
  int  holds_requested = 0;

  // Store one accepted word; on the last word, sort the batch with the same
  // swap order as the block and queue its words in output order.
  function automatic void absorb_record(input logic signed [KEY_W-1:0] key,
                                        input logic [TAG_W-1:0] tag,
                                        input logic last);
    logic signed [KEY_W-1:0] k_tmp;
    logic [TAG_W-1:0]        t_tmp;
    sorted_rec_t             rec;
    if (batch_fill < CAPACITY) begin
      batch_keys[batch_fill] = key;
      batch_tags[batch_fill] = tag;
      batch_fill++;
    end else begin
      batch_overflow = 1'b1;
    end
    if (!last) return;
    for (int i = 0; i < batch_fill; i++) begin
      for (int j = 0; j < i; j++) begin
        if (batch_keys[i] < batch_keys[j]) begin
          k_tmp = batch_keys[i];
          t_tmp = batch_tags[i];
          batch_keys[i] = batch_keys[j];
          batch_tags[i] = batch_tags[j];
          batch_keys[j] = k_tmp;
          batch_tags[j] = t_tmp;
        end
      end
    end
    for (int k = 0; k < batch_fill; k++) begin
      rec.key = batch_keys[k];
      rec.tag = batch_tags[k];
      rec.last = (k + 1 == batch_fill);
      rec.dropped = batch_overflow;
      expected_recs.push_back(rec);
    end
    batch_fill = 0;
    batch_overflow = 1'b0;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (quiet_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key(input key_mix_t mix);
    int v;
    case (mix)
      KEYS_NARROW: begin
        v = $urandom_range(0, 8);
        return v - 4;
      end
      KEYS_EDGE: begin
        case ($urandom_range(0, 5))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return KEY_MIN + 1;
          3: return KEY_MAX - 1;
          4: return -1;
          default: return 0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Offer one word after a random gap and hold it until it is taken.
  task automatic send_word(input logic signed [KEY_W-1:0] key,
                           input logic [TAG_W-1:0] tag,
                           input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.key <= key;
    in_ch.tag <= tag;
    in_ch.last <= last;
    do @(posedge clk); while (!in_ch.ready);
    absorb_record(key, tag, last);
    words_sent++;
  endtask

  task automatic send_batch(input int count, input key_mix_t mix);
    for (int n = 0; n < count; n++) begin
      send_word(pick_key(mix), TAG_W'($urandom_range(0, 16'hFFFF)), n == count - 1);
    end
  endtask

  // Withdraw the offered word, then wait until every sorted word has come back.
  task automatic wait_all_sorted();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (expected_recs.size() != 0) @(posedge clk);
  endtask

  // Batches of one word at both ends of the key and tag ranges.
  task automatic test_single_records();
    send_word(KEY_MIN, 16'hFFFF, 1'b1);
    send_word(KEY_MAX, 16'h0000, 1'b1);
  endtask

  // Extreme keys mixed with values near zero, then a reversed batch.
  task automatic test_extreme_keys();
    send_word(KEY_MAX, 16'h0001, 1'b0);
    send_word(KEY_MIN, 16'h0002, 1'b0);
    send_word(0,       16'h0004, 1'b0);
    send_word(-1,      16'h0008, 1'b0);
    send_word(1,       16'h0010, 1'b0);
    send_word(KEY_MIN, 16'h5555, 1'b0);
    send_word(KEY_MAX, 16'hAAAA, 1'b1);
    send_word(4, 16'h0104, 1'b0);
    send_word(3, 16'h0103, 1'b0);
    send_word(2, 16'h0102, 1'b0);
    send_word(1, 16'h0101, 1'b1);
  endtask

  // Repeated keys: the tag order shows the tie order of the swap pattern.
  task automatic test_equal_keys();
    send_word(3,  16'h0A01, 1'b0);
    send_word(-2, 16'h0A02, 1'b0);
    send_word(3,  16'h0A03, 1'b0);
    send_word(3,  16'h0A04, 1'b0);
    send_word(-2, 16'h0A05, 1'b0);
    send_word(3,  16'h0A06, 1'b1);
  endtask

  // A batch that fills the store exactly, then one whose last word is dropped.
  // The sender then pauses until every sorted word has come back.
  task automatic test_capacity();
    send_batch(CAPACITY, KEYS_FULL);
    send_batch(CAPACITY + 1, KEYS_NARROW);
    wait_all_sorted();
  endtask

  // The receiver holds off while the sender keeps offering batches, so the
  // block stops taking words until its sorted batch has been delivered.
  task automatic test_sink_hold();
    quiet_gaps = 1'b1;
    holds_requested++;
    send_batch(5, KEYS_FULL);
    send_batch(6, KEYS_NARROW);
    send_batch(4, KEYS_EDGE);
    quiet_gaps = 1'b0;
  endtask

  // Random batches, mostly small, a few large (up to full) or overflowing.
  task automatic test_random_batches();
    int r;
    int count;
    key_mix_t mix;
    while (words_sent < TOTAL_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 70) count = $urandom_range(1, 8);
      else if (r < 90) count = $urandom_range(9, 32);
      else if (r < 97) count = $urandom_range(33, CAPACITY);
      else count = $urandom_range(CAPACITY + 1, CAPACITY + 8);
      r = $urandom_range(0, 9);
      if (r < 5) mix = KEYS_FULL;
      else if (r < 8) mix = KEYS_NARROW;
      else mix = KEYS_EDGE;
      quiet_gaps = ($urandom_range(0, 4) == 0);
      send_batch(count, mix);
    end
    quiet_gaps = 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin : sink_side
    int stall_left;
    int hold_left;
    int holds_served;
    logic rdy;
    stall_left = 0;
    hold_left = 0;
    holds_served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_requested) begin
        hold_left = SINK_HOLD_CYCLES;
        holds_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        rdy = (stall_left == 0);
        if (!rdy) stall_left--;
      end else begin
        rdy = 1'b1;
      end
      out_ch.ready <= rdy;
    end
  end

  // Compare every delivered word with the oldest expected one.
  always @(posedge clk) begin : check_results
    sorted_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_recs.size() == 0) begin
        $display("%0t: unexpected word, key %0d tag %0h last %0b dropped %0b", $time,
                 out_ch.key_out, out_ch.tag_out, out_ch.last_out, out_ch.dropped);
        mismatches++;
      end else begin
        want = expected_recs.pop_front();
        if (out_ch.key_out !== want.key) begin
          $display("%0t: key_out expected %0d, got %0d", $time, want.key, out_ch.key_out);
          mismatches++;
        end
        if (out_ch.tag_out !== want.tag) begin
          $display("%0t: tag_out expected %0h, got %0h", $time, want.tag, out_ch.tag_out);
          mismatches++;
        end
        if (out_ch.last_out !== want.last) begin
          $display("%0t: last_out expected %0b, got %0b", $time, want.last,
                   out_ch.last_out);
          mismatches++;
        end
        if (out_ch.dropped !== want.dropped) begin
          $display("%0t: dropped expected %0b, got %0b", $time, want.dropped,
                   out_ch.dropped);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run.
  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  // Reset once, run the tests in turn, then drain and report.
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.key = '0;
    in_ch.tag = '0;
    in_ch.last = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_single_records();
    test_extreme_keys();
    test_equal_keys();
    test_capacity();
    test_sink_hold();
    test_random_batches();

    @(negedge clk) in_ch.valid <= 1'b0;
    wait_all_sorted();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_recs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
